// ===== src/c2d_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2d_pkg: shared types and constants for the convolution core
// Mode codes, register indexes and sequencer states.
// ----------------------------------------------------------------------------
package c2d_pkg;

  localparam int unsigned MaxInChannels  = 16;
  localparam int unsigned MaxOutChannels = 16;
  localparam int unsigned MaxHeight      = 32;
  localparam int unsigned MaxWidth       = 32;
  localparam int unsigned MaxKernel      = 8;

  localparam int unsigned CfgWidth = 6;
  localparam int unsigned CfgIdxWidth = 3;

  typedef enum logic [1:0] {
    MODE_WEIGHT = 2'd0,
    MODE_BIAS   = 2'd1,
    MODE_ACT    = 2'd2,
    MODE_REQ    = 2'd3
  } mode_e;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_IN_CH  = 3'd0,
    REG_OUT_CH = 3'd1,
    REG_IN_H   = 3'd2,
    REG_IN_W   = 3'd3,
    REG_K_H    = 3'd4,
    REG_K_W    = 3'd5,
    REG_STRIDE = 3'd6,
    REG_PAD    = 3'd7
  } reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIMS,
    ST_CHECK,
    ST_ISSUE,
    ST_DRAIN,
    ST_ROUND,
    ST_EMIT
  } state_e;

endpackage

// ===== src/conv2d_stride_pad_bias_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// conv2d_stride_pad_bias_core: Q8.8 2-D convolution, one output point a request
//
// channel  | signals                                  | direction
// command  | start_i, busy_o, mode_i .. col_index_i   | in (busy_o out)
// result   | done_o, result_value_o, status_o, saturated_o | out
// config   | cfg_we_i, cfg_idx_i, cfg_data_i          | in
//
// A request holds busy through the ST_DIMS and ST_CHECK set-up states, one tap
// a cycle through the shared multiply-accumulate, paced by the single read port
// of each store, the drain of the product pipe, rounding and emit. Out-of-map
// requests go from ST_CHECK straight to ST_EMIT. The result beat follows in the
// cycle after busy. Reset sets config registers to defaults and clears the state,
// tap valid flags and bias store; datapath registers and the weight and activation
// RAMs are not cleared. Results are strobed for one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
module conv2d_stride_pad_bias_core
  import c2d_pkg::*;
#(
  parameter int unsigned MAX_IN_CHANNELS  = MaxInChannels,
  parameter int unsigned MAX_OUT_CHANNELS = MaxOutChannels,
  parameter int unsigned MAX_HEIGHT       = MaxHeight,
  parameter int unsigned MAX_WIDTH        = MaxWidth,
  parameter int unsigned MAX_KERNEL       = MaxKernel
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  output logic                   busy_o,
  input  logic [1:0]             mode_i,
  input  logic signed [15:0]     value_i,
  input  logic [3:0]             filter_index_i,
  input  logic [3:0]             channel_index_i,
  input  logic [4:0]             row_index_i,
  input  logic [4:0]             col_index_i,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [CfgWidth-1:0]    cfg_data_i,
  output logic                   done_o,
  output logic signed [15:0]     result_value_o,
  output logic                   status_o,
  output logic                   saturated_o
);

  localparam int unsigned CW  = $clog2(MAX_IN_CHANNELS) > 0 ? $clog2(MAX_IN_CHANNELS) : 1;
  localparam int unsigned FW  = $clog2(MAX_OUT_CHANNELS) > 0 ? $clog2(MAX_OUT_CHANNELS) : 1;
  localparam int unsigned HW  = $clog2(MAX_HEIGHT);
  localparam int unsigned WW  = $clog2(MAX_WIDTH);
  localparam int unsigned KW  = $clog2(MAX_KERNEL) > 0 ? $clog2(MAX_KERNEL) : 1;
  localparam int unsigned ActDepth = MAX_IN_CHANNELS * MAX_HEIGHT * MAX_WIDTH;
  localparam int unsigned WgtDepth = MAX_OUT_CHANNELS * MAX_IN_CHANNELS * MAX_KERNEL * MAX_KERNEL;
  localparam int unsigned AAW = $clog2(ActDepth);
  localparam int unsigned WAW = $clog2(WgtDepth);
  localparam int unsigned AccW = 48;

  // configuration registers
  logic [4:0] in_ch_q, out_ch_q;
  logic [5:0] in_h_q, in_w_q;
  logic [3:0] k_h_q, k_w_q, stride_q;
  logic [2:0] pad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch_q <= 5'd1; out_ch_q <= 5'd1; in_h_q <= 6'd32; in_w_q <= 6'd32;
      k_h_q <= 4'd3; k_w_q <= 4'd3; stride_q <= 4'd1; pad_q <= 3'd0;
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_idx_i))
        REG_IN_CH:  in_ch_q  <= cfg_data_i[4:0];
        REG_OUT_CH: out_ch_q <= cfg_data_i[4:0];
        REG_IN_H:   in_h_q   <= cfg_data_i[5:0];
        REG_IN_W:   in_w_q   <= cfg_data_i[5:0];
        REG_K_H:    k_h_q    <= cfg_data_i[3:0];
        REG_K_W:    k_w_q    <= cfg_data_i[3:0];
        REG_STRIDE: stride_q <= cfg_data_i[3:0];
        REG_PAD:    pad_q    <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  function automatic logic [9:0] sat_rng(input logic [9:0] v, input logic [9:0] hi);
    if (v == 10'd0) return 10'd1;
    if (v > hi) return hi;
    return v;
  endfunction

  // effective dims, registered in ST_DIMS
  logic [9:0] ic_q, h_q, w_q, kh_q, kw_q;
  logic [9:0] ic_d, oc_d, h_d, w_d, kh_d, kw_d, s_d, ph_d, pw_d;

  always_comb begin
    ic_d = sat_rng({5'd0, in_ch_q}, 10'(MAX_IN_CHANNELS));
    oc_d = sat_rng({5'd0, out_ch_q}, 10'(MAX_OUT_CHANNELS));
    h_d  = sat_rng({4'd0, in_h_q}, 10'(MAX_HEIGHT));
    w_d  = sat_rng({4'd0, in_w_q}, 10'(MAX_WIDTH));
    kh_d = sat_rng({6'd0, k_h_q}, 10'(MAX_KERNEL));
    kw_d = sat_rng({6'd0, k_w_q}, 10'(MAX_KERNEL));
    s_d  = (stride_q == 4'd0) ? 10'd1 : {6'd0, stride_q};
    ph_d = h_d + {6'd0, pad_q, 1'b0};
    pw_d = w_d + {6'd0, pad_q, 1'b0};
  end

  // output map extent: out >= (p-k)/s+1 test done as r*s+k > p (no divider)
  state_e state_q, state_d;

  logic [FW-1:0] f_q;
  logic [4:0]    orow_q, ocol_q;
  logic [CW-1:0] ci_q;
  logic [KW-1:0] kr_q, kc_q;
  logic signed [10:0] y0_q, x0_q; // r*s - pad
  logic signed [AccW-1:0] acc_q;
  logic          tap_v_q, tap_v2_q;
  logic signed [15:0] bias_q [MAX_OUT_CHANNELS];
  logic          bad_q;
  logic signed [15:0] res_q;
  logic          sat_q, stat_q, done_q;

  // tap geometry
  logic signed [11:0] y_t, x_t;
  logic tap_ok, last_tap;
  always_comb begin
    y_t = 12'(y0_q) + 12'($signed({1'b0, kr_q}));
    x_t = 12'(x0_q) + 12'($signed({1'b0, kc_q}));
    tap_ok = (y_t >= 0) && (y_t < $signed({2'b0, h_q})) &&
             (x_t >= 0) && (x_t < $signed({2'b0, w_q}));
    last_tap = ({{(10-CW){1'b0}}, ci_q} == ic_q - 10'd1) &&
               ({{(10-KW){1'b0}}, kr_q} == kh_q - 10'd1) &&
               ({{(10-KW){1'b0}}, kc_q} == kw_q - 10'd1);
  end

  // RAMs
  logic          a_we, w_we;
  logic [AAW-1:0] a_waddr, a_raddr;
  logic [WAW-1:0] w_waddr, w_raddr;
  logic signed [15:0] a_rdata, w_rdata;

  always_comb begin
    a_waddr = AAW'((32'(channel_index_i) * MAX_HEIGHT + 32'(row_index_i)) * MAX_WIDTH
                   + 32'(col_index_i));
    w_waddr = WAW'(((32'(filter_index_i) * MAX_IN_CHANNELS + 32'(channel_index_i))
                    * MAX_KERNEL + 32'(row_index_i)) * MAX_KERNEL + 32'(col_index_i));
    a_raddr = AAW'((32'(ci_q) * MAX_HEIGHT + 32'(y_t[HW:0] & {(HW+1){1'b1}}))
                   * MAX_WIDTH + 32'(x_t[WW:0]));
    w_raddr = WAW'(((32'(f_q) * MAX_IN_CHANNELS + 32'(ci_q)) * MAX_KERNEL + 32'(kr_q))
                   * MAX_KERNEL + 32'(kc_q));
    a_we = start_i && !busy_o && (mode_i == MODE_ACT) &&
           (32'(channel_index_i) < MAX_IN_CHANNELS) && (32'(row_index_i) < MAX_HEIGHT) &&
           (32'(col_index_i) < MAX_WIDTH);
    w_we = start_i && !busy_o && (mode_i == MODE_WEIGHT) &&
           (32'(filter_index_i) < MAX_OUT_CHANNELS) &&
           (32'(channel_index_i) < MAX_IN_CHANNELS) &&
           (32'(row_index_i) < MAX_KERNEL) && (32'(col_index_i) < MAX_KERNEL);
  end

  c2d_ram #(.Width(16), .Depth(ActDepth)) u_act (
    .clk_i, .we_i(a_we), .waddr_i(a_waddr), .wdata_i(value_i),
    .raddr_i(a_raddr), .rdata_o(a_rdata)
  );
  c2d_ram #(.Width(16), .Depth(WgtDepth)) u_wgt (
    .clk_i, .we_i(w_we), .waddr_i(w_waddr), .wdata_i(value_i),
    .raddr_i(w_raddr), .rdata_o(w_rdata)
  );

  // shared multiplier, registered product
  logic signed [31:0] prod_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (start_i && mode_i == MODE_REQ) state_d = ST_DIMS;
      ST_DIMS:  state_d = ST_CHECK;
      ST_CHECK: state_d = bad_q ? ST_EMIT : ST_ISSUE;
      ST_ISSUE: if (last_tap) state_d = ST_DRAIN;
      ST_DRAIN: if (!tap_v_q && !tap_v2_q) state_d = ST_ROUND;
      ST_ROUND: state_d = ST_EMIT;
      ST_EMIT:  state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy_o = (state_q != ST_IDLE);
    done_o = done_q;
    result_value_o = res_q;
    status_o = stat_q;
    saturated_o = sat_q;
  end

  logic signed [AccW-1:0] q_fl;
  always_comb q_fl = acc_q >>> 8; // floor

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q <= 1'b0;
      tap_v_q <= 1'b0;
      tap_v2_q <= 1'b0;
      for (int i = 0; i < int'(MAX_OUT_CHANNELS); i++) bias_q[i] <= '0;
    end else begin
      state_q <= state_d;
      done_q <= (state_q == ST_EMIT);
      tap_v_q <= (state_q == ST_ISSUE) && tap_ok;
      tap_v2_q <= tap_v_q;
      if (start_i && !busy_o && mode_i == MODE_BIAS &&
          32'(filter_index_i) < MAX_OUT_CHANNELS) begin
        bias_q[FW'(filter_index_i)] <= value_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start_i) begin
      f_q <= FW'(filter_index_i);
      orow_q <= row_index_i;
      ocol_q <= col_index_i;
      bad_q <= (32'(filter_index_i) >= MAX_OUT_CHANNELS);
    end
    if (state_q == ST_DIMS) begin
      ic_q <= ic_d; h_q <= h_d; w_q <= w_d;
      kh_q <= kh_d; kw_q <= kw_d;
      // row*s + k must fit in padded extent
      bad_q <= bad_q || ({{(10-FW){1'b0}}, f_q} >= oc_d) ||
               (10'({5'd0, orow_q} * s_d) + kh_d > ph_d) ||
               (10'({5'd0, ocol_q} * s_d) + kw_d > pw_d) ||
               (ph_d < kh_d) || (pw_d < kw_d);
      y0_q <= 11'($signed({1'b0, 10'({5'd0, orow_q} * s_d)})) - 11'($signed({8'd0, pad_q}));
      x0_q <= 11'($signed({1'b0, 10'({5'd0, ocol_q} * s_d)})) - 11'($signed({8'd0, pad_q}));
      ci_q <= '0; kr_q <= '0; kc_q <= '0;
      acc_q <= AccW'(bias_q[f_q]) <<< 8;
    end
    if (state_q == ST_ISSUE) begin
      if ({{(10-KW){1'b0}}, kc_q} == kw_q - 10'd1) begin
        kc_q <= '0;
        if ({{(10-KW){1'b0}}, kr_q} == kh_q - 10'd1) begin
          kr_q <= '0;
          ci_q <= ci_q + CW'(1);
        end else begin
          kr_q <= kr_q + KW'(1);
        end
      end else begin
        kc_q <= kc_q + KW'(1);
      end
    end
    prod_q <= w_rdata * a_rdata;
    if (tap_v2_q) acc_q <= acc_q + AccW'(prod_q);
    if (state_q == ST_ROUND) begin
      stat_q <= 1'b0;
      if (q_fl > 32767) begin
        res_q <= 16'sd32767; sat_q <= 1'b1;
      end else if (q_fl < -32768) begin
        res_q <= -16'sd32768; sat_q <= 1'b1;
      end else begin
        res_q <= q_fl[15:0]; sat_q <= 1'b0;
      end
    end
    if (state_q == ST_CHECK && bad_q) begin
      res_q <= '0; sat_q <= 1'b0; stat_q <= 1'b1;
    end
  end

  // product pipeline must be empty when the result is rounded
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROUND) |-> (!tap_v_q && !tap_v2_q))
    else $error("tap in flight at rounding");
  // strobe only follows the emit state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == ST_EMIT))
    else $error("stray result strobe");
  // a bad request never carries data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o) |-> (result_value_o == 16'sd0 && !saturated_o))
    else $error("error result carries data");

endmodule

// ===== src/c2d_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2d_ram: generic simple dual-port RAM
// One write and one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module c2d_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== verif/conv2d_point_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// conv2d_point_checker: scoreboard for the convolution core
// Mirrors the weight, activation and bias stores and the dimension registers,
// works out each requested output point and compares it with the strobed beat.
// ----------------------------------------------------------------------------
module conv2d_point_checker
  import c2d_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic                   busy_o,
  input  logic [1:0]             mode_i,
  input  logic signed [15:0]     value_i,
  input  logic [3:0]             filter_index_i,
  input  logic [3:0]             channel_index_i,
  input  logic [4:0]             row_index_i,
  input  logic [4:0]             col_index_i,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [CfgWidth-1:0]    cfg_data_i,
  input  logic                   done_o,
  input  logic signed [15:0]     result_value_o,
  input  logic                   status_o,
  input  logic                   saturated_o,
  output int unsigned            pending_o,
  output int unsigned            errors_o
);

  localparam int unsigned WgtDepth = MaxOutChannels * MaxInChannels * MaxKernel * MaxKernel;
  localparam int unsigned ActDepth = MaxInChannels * MaxHeight * MaxWidth;

  typedef struct packed {
    logic signed [15:0] value;
    logic               status;
    logic               sat;
  } point_t;

  logic signed [15:0] wgt_mem [WgtDepth];
  logic signed [15:0] act_mem [ActDepth];
  logic signed [15:0] bias_mem [MaxOutChannels];
  logic [4:0] in_ch_q, out_ch_q;
  logic [5:0] in_h_q, in_w_q;
  logic [3:0] k_h_q, k_w_q, stride_q;
  logic [2:0] pad_q;
  point_t     point_q[$];

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic point_t conv_point(int unsigned f, int unsigned r, int unsigned c);
    int unsigned ic, oc, h, w, kh, kw, s, p, oh, ow;
    int          y, x;
    longint      acc;
    point_t      pt;
    ic = clamp_dim(in_ch_q, MaxInChannels);
    oc = clamp_dim(out_ch_q, MaxOutChannels);
    h  = clamp_dim(in_h_q, MaxHeight);
    w  = clamp_dim(in_w_q, MaxWidth);
    kh = clamp_dim(k_h_q, MaxKernel);
    kw = clamp_dim(k_w_q, MaxKernel);
    s  = (stride_q == 0) ? 1 : stride_q;
    p  = pad_q;
    oh = (h + 2 * p >= kh) ? (h + 2 * p - kh) / s + 1 : 0;
    ow = (w + 2 * p >= kw) ? (w + 2 * p - kw) / s + 1 : 0;
    pt = '0;
    if (f >= oc || r >= oh || c >= ow) begin
      pt.status = 1'b1;
      return pt;
    end
    acc = longint'(bias_mem[f]) * 256;
    for (int ci = 0; ci < ic; ci++) begin
      for (int kr = 0; kr < kh; kr++) begin
        y = int'(r * s) + kr - int'(p);
        if (y < 0 || y >= int'(h)) continue;
        for (int kc = 0; kc < kw; kc++) begin
          x = int'(c * s) + kc - int'(p);
          if (x < 0 || x >= int'(w)) continue;
          acc += longint'(wgt_mem[((f * MaxInChannels + ci) * MaxKernel + kr) * MaxKernel + kc])
               * longint'(act_mem[(ci * MaxHeight + y) * MaxWidth + x]);
        end
      end
    end
    acc = acc >>> 8;  // floor to Q8.8
    if (acc > 32767) begin
      acc = 32767;
      pt.sat = 1'b1;
    end else if (acc < -32768) begin
      acc = -32768;
      pt.sat = 1'b1;
    end
    pt.value = acc[15:0];
    return pt;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    point_t got, want;
    if (!rst_ni) begin
      foreach (bias_mem[i]) bias_mem[i] = '0;
      in_ch_q  = 5'd1;
      out_ch_q = 5'd1;
      in_h_q   = 6'd32;
      in_w_q   = 6'd32;
      k_h_q    = 4'd3;
      k_w_q    = 4'd3;
      stride_q = 4'd1;
      pad_q    = 3'd0;
      point_q.delete();
      errors_o  = 0;
      pending_o = 0;
    end else begin
      if (done_o) begin
        got = '{result_value_o, status_o, saturated_o};
        if (point_q.size() == 0) begin
          errors_o++;
          if (errors_o <= 10)
            $display("%0t: unexpected result beat %0d st %0b sat %0b", $realtime,
                     got.value, got.status, got.sat);
        end else begin
          want = point_q.pop_front();
          if (got !== want) begin
            errors_o++;
            if (errors_o <= 10)
              $display("%0t: point mismatch exp %0d/%0b/%0b got %0d/%0b/%0b", $realtime,
                       want.value, want.status, want.sat, got.value, got.status, got.sat);
          end
        end
      end
      if (cfg_we_i) begin
        case (reg_e'(cfg_idx_i))
          REG_IN_CH:  in_ch_q  = cfg_data_i[4:0];
          REG_OUT_CH: out_ch_q = cfg_data_i[4:0];
          REG_IN_H:   in_h_q   = cfg_data_i[5:0];
          REG_IN_W:   in_w_q   = cfg_data_i[5:0];
          REG_K_H:    k_h_q    = cfg_data_i[3:0];
          REG_K_W:    k_w_q    = cfg_data_i[3:0];
          REG_STRIDE: stride_q = cfg_data_i[3:0];
          REG_PAD:    pad_q    = cfg_data_i[2:0];
          default: ;
        endcase
      end
      if (start_i && !busy_o) begin
        case (mode_e'(mode_i))
          MODE_WEIGHT: begin
            if (row_index_i < MaxKernel && col_index_i < MaxKernel)
              wgt_mem[((filter_index_i * MaxInChannels + channel_index_i) * MaxKernel
                       + row_index_i) * MaxKernel + col_index_i] = value_i;
          end
          MODE_BIAS: bias_mem[filter_index_i] = value_i;
          MODE_ACT: begin
            act_mem[(channel_index_i * MaxHeight + row_index_i) * MaxWidth + col_index_i]
              = value_i;
          end
          default: point_q.push_back(conv_point(filter_index_i, row_index_i, col_index_i));
        endcase
      end
      pending_o = point_q.size();
    end
  end

endmodule

// ===== verif/conv2d_stride_pad_bias_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// conv2d_stride_pad_bias_core_test: top of the convolution core testbench
// Drives directed and random load/request beats in bursts over several
// dimension settings; the checker scores every output point.
// ----------------------------------------------------------------------------
module conv2d_stride_pad_bias_core_test;
  import c2d_pkg::*;

  localparam int unsigned IdleLimit = 20000;
  localparam int unsigned PhaseBeats = 64;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   start_i = 1'b0;
  logic                   busy_o;
  logic [1:0]             mode_i = MODE_WEIGHT;
  logic signed [15:0]     value_i = '0;
  logic [3:0]             filter_index_i = '0;
  logic [3:0]             channel_index_i = '0;
  logic [4:0]             row_index_i = '0;
  logic [4:0]             col_index_i = '0;
  logic                   cfg_we_i = 1'b0;
  logic [CfgIdxWidth-1:0] cfg_idx_i = REG_IN_CH;
  logic [CfgWidth-1:0]    cfg_data_i = '0;
  logic                   done_o;
  logic signed [15:0]     result_value_o;
  logic                   status_o;
  logic                   saturated_o;
  int unsigned            pending, errors;

  bit          wgt_ok [MaxOutChannels * MaxInChannels * MaxKernel * MaxKernel];
  bit          act_ok [MaxInChannels * MaxHeight * MaxWidth];
  int unsigned cfg_sh [8] = '{1, 1, 32, 32, 3, 3, 1, 0};
  int unsigned burst_left = 0;
  int unsigned idle_cycles = 0;
  int unsigned sent = 0;

  // raw register values per setting: in_ch out_ch h w kh kw stride pad
  int unsigned settings [8][8] = '{
    '{1, 1, 32, 32, 3, 3, 1, 0},
    '{2, 3, 5, 6, 2, 3, 1, 1},
    '{31, 31, 1, 1, 15, 15, 8, 7},
    '{1, 2, 63, 63, 1, 1, 2, 0},
    '{3, 2, 4, 4, 5, 5, 1, 0},
    '{2, 2, 7, 5, 3, 2, 0, 2},
    '{0, 0, 0, 0, 0, 0, 15, 3},
    '{4, 16, 6, 6, 2, 2, 2, 1}
  };

  initial forever #5 clk_i = ~clk_i;

  conv2d_stride_pad_bias_core dut (.*);

  conv2d_point_checker u_checker (
    .*,
    .pending_o (pending),
    .errors_o  (errors)
  );

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o || cfg_we_i) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void map_dims(output int unsigned ic, oc, h, w, kh, kw, s, p, oh, ow);
    ic = clamp_dim(cfg_sh[REG_IN_CH], MaxInChannels);
    oc = clamp_dim(cfg_sh[REG_OUT_CH], MaxOutChannels);
    h  = clamp_dim(cfg_sh[REG_IN_H], MaxHeight);
    w  = clamp_dim(cfg_sh[REG_IN_W], MaxWidth);
    kh = clamp_dim(cfg_sh[REG_K_H], MaxKernel);
    kw = clamp_dim(cfg_sh[REG_K_W], MaxKernel);
    s  = (cfg_sh[REG_STRIDE] == 0) ? 1 : cfg_sh[REG_STRIDE];
    p  = cfg_sh[REG_PAD];
    oh = (h + 2 * p >= kh) ? (h + 2 * p - kh) / s + 1 : 0;
    ow = (w + 2 * p >= kw) ? (w + 2 * p - kw) / s + 1 : 0;
  endfunction

  task automatic send(mode_e m, int unsigned v, int unsigned f, int unsigned c,
                      int unsigned r, int unsigned col);
    int unsigned gap;
    logic [3:0]  fi, chi;
    logic [4:0]  ri, cj;
    fi  = 4'(f);
    chi = 4'(c);
    ri  = 5'(r);
    cj  = 5'(col);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        start_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    mode_i          <= m;
    value_i         <= 16'(v);
    filter_index_i  <= fi;
    channel_index_i <= chi;
    row_index_i     <= ri;
    col_index_i     <= cj;
    start_i         <= 1'b1;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    burst_left--;
    sent++;
    if (m == MODE_WEIGHT && ri < MaxKernel && cj < MaxKernel)
      wgt_ok[((fi * MaxInChannels + chi) * MaxKernel + ri) * MaxKernel + cj] = 1'b1;
    if (m == MODE_ACT)
      act_ok[(chi * MaxHeight + ri) * MaxWidth + cj] = 1'b1;
  endtask

  // loads any tap the point would read that was never written, then asks for it
  task automatic ask(int unsigned f, int unsigned r, int unsigned col);
    int unsigned ic, oc, h, w, kh, kw, s, p, oh, ow;
    int          y, x;
    logic [3:0]  fi;
    logic [4:0]  ri, cj;
    fi = 4'(f);
    ri = 5'(r);
    cj = 5'(col);
    map_dims(ic, oc, h, w, kh, kw, s, p, oh, ow);
    if (fi < oc && ri < oh && cj < ow) begin
      for (int ci = 0; ci < ic; ci++) begin
        for (int kr = 0; kr < kh; kr++) begin
          y = int'(ri * s) + kr - int'(p);
          if (y < 0 || y >= int'(h)) continue;
          for (int kc = 0; kc < kw; kc++) begin
            x = int'(cj * s) + kc - int'(p);
            if (x < 0 || x >= int'(w)) continue;
            if (!wgt_ok[((fi * MaxInChannels + ci) * MaxKernel + kr) * MaxKernel + kc])
              send(MODE_WEIGHT, $urandom, fi, ci, kr, kc);
            if (!act_ok[(ci * MaxHeight + y) * MaxWidth + x])
              send(MODE_ACT, $urandom, $urandom, ci, y, x);
          end
        end
      end
    end
    send(MODE_REQ, $urandom, fi, $urandom, ri, cj);
  endtask

  task automatic set_reg(reg_e idx, int unsigned v);
    int unsigned widths [8] = '{5, 5, 6, 6, 4, 4, 4, 3};
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= CfgWidth'(v);
    @(posedge clk_i);
    cfg_sh[idx] = v & ((1 << widths[idx]) - 1);
  endtask

  // lets every outstanding point come back; the core holds no work after that
  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  initial begin
    int unsigned ic, oc, h, w, kh, kw, s, p, oh, ow, beats;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed beats on a 1x1 kernel, 32x32 map
    set_reg(REG_K_H, 1);
    set_reg(REG_K_W, 1);
    cfg_we_i <= 1'b0;
    send(MODE_BIAS, 16'h7fff, 0, 0, 0, 0);
    send(MODE_WEIGHT, 16'h8000, 0, 0, 0, 0);
    send(MODE_ACT, 16'h8000, 0, 0, 0, 0);
    ask(0, 0, 0);                               // positive clamp
    send(MODE_WEIGHT, 16'h7fff, 0, 0, 0, 0);
    ask(0, 0, 0);                               // negative clamp
    send(MODE_WEIGHT, 16'h0001, 0, 0, 0, 0);
    send(MODE_ACT, 16'hffff, 15, 0, 0, 0);
    send(MODE_BIAS, 16'h0000, 0, 0, 0, 0);
    ask(0, 0, 0);                               // floor of a tiny negative
    send(MODE_BIAS, 16'h8000, 0, 0, 0, 0);
    ask(0, 0, 0);                               // bias at the floor tips over
    ask(0, 31, 31);
    ask(1, 0, 0);                               // filter beyond the filters in use
    ask(15, 31, 31);
    send(MODE_WEIGHT, 16'h1234, 0, 0, 8, 31);   // outside the kernel store, dropped
    send(MODE_WEIGHT, 16'hedcb, 15, 15, 7, 7);
    send(MODE_ACT, 16'h5a5a, 15, 15, 31, 31);
    send(MODE_BIAS, 16'h8000, 15, 0, 0, 0);
    drain();

    foreach (settings[k]) begin
      for (int i = 0; i < 8; i++) set_reg(reg_e'(i), settings[k][i]);
      cfg_we_i <= 1'b0;
      map_dims(ic, oc, h, w, kh, kw, s, p, oh, ow);
      beats = sent;
      while (sent < beats + PhaseBeats) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: begin
            if ($urandom_range(0, 6) == 0 || oh == 0 || ow == 0)
              ask($urandom, $urandom, $urandom);
            else
              ask($urandom_range(0, oc - 1), $urandom_range(0, oh - 1),
                  $urandom_range(0, ow - 1));
          end
          5:       send(MODE_WEIGHT, $urandom, $urandom, $urandom, $urandom, $urandom);
          6:       send(MODE_WEIGHT, $urandom, $urandom_range(0, oc - 1),
                        $urandom_range(0, ic - 1), $urandom_range(0, kh - 1),
                        $urandom_range(0, kw - 1));
          7, 8:    send(MODE_ACT, $urandom, $urandom, $urandom, $urandom, $urandom);
          default: send(MODE_BIAS, $urandom, $urandom, $urandom, $urandom, $urandom);
        endcase
      end
      drain();
    end

    repeat (64) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/c2d_pkg.sv
src/c2d_ram.sv
src/conv2d_stride_pad_bias_core.sv
verif/conv2d_point_checker.sv
verif/conv2d_stride_pad_bias_core_test.sv
